/* src/rbsi_pkg.sv */
// Shared types and constants for the ray / box slab intersection block.
// No dependencies; used by every module and interface in src.
package rbsi_pkg;

  localparam int unsigned Q_W     = 32;             // Q16.16 coordinate width
  localparam int unsigned FRAC_W  = 16;             // fraction bits
  localparam int unsigned THR_W   = 16;             // threshold register width
  localparam int unsigned DIFF_W  = Q_W + 1;        // bound - origin, exact
  localparam int unsigned NUM_W   = DIFF_W + FRAC_W; // |diff| << 16
  localparam int unsigned DEN_W   = Q_W;            // |dir|, up to 2^31
  localparam int unsigned DIST_W  = Q_W - 1;        // unsigned hit distance
  localparam int unsigned N_LANES = 3;              // x, y, z

  // setup + one stage per quotient bit + saturate + order
  localparam int unsigned LANE_LAT  = NUM_W + 3;
  localparam int unsigned MERGE_LAT = 2;
  localparam int unsigned PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // What one axis lane reports to the merge stage
  typedef struct packed {
    logic                  par;       // axis treated as parallel
    logic                  par_miss;  // parallel and origin outside slab
    logic signed [Q_W-1:0] t0;        // entry parameter
    logic signed [Q_W-1:0] t1;        // exit parameter
  } lane_res_t;

endpackage

/* src/rbsi_in_if.sv */
// Input channel: one ray and one box per beat, valid/ready handshake.
// Depends on rbsi_pkg for the coordinate width.
interface rbsi_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [rbsi_pkg::Q_W-1:0] origin_x;
  logic signed [rbsi_pkg::Q_W-1:0] origin_y;
  logic signed [rbsi_pkg::Q_W-1:0] origin_z;
  logic signed [rbsi_pkg::Q_W-1:0] dir_x;
  logic signed [rbsi_pkg::Q_W-1:0] dir_y;
  logic signed [rbsi_pkg::Q_W-1:0] dir_z;
  logic signed [rbsi_pkg::Q_W-1:0] box_min_x;
  logic signed [rbsi_pkg::Q_W-1:0] box_min_y;
  logic signed [rbsi_pkg::Q_W-1:0] box_min_z;
  logic signed [rbsi_pkg::Q_W-1:0] box_max_x;
  logic signed [rbsi_pkg::Q_W-1:0] box_max_y;
  logic signed [rbsi_pkg::Q_W-1:0] box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

/* src/rbsi_out_if.sv */
// Result channel: hit flag and entry distance per beat, valid/ready handshake.
// Depends on rbsi_pkg for the distance width.
interface rbsi_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [rbsi_pkg::DIST_W-1:0]    hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink   (input valid, hit, hit_distance, output ready);
endinterface

/* src/ray_box_slab_intersect.sv */
// Ray / axis-aligned box slab test, fully pipelined: one ray-box beat is taken
// every cycle while the skid slot is empty, and passes through setup, 49
// stages of the bit-per-stage quotient pipeline, saturate, order, two merge
// stages and the output register. Each of the x, y, z axes has its own lane
// with two dividers; a two-entry output buffer lets one more beat enter while
// a result waits. cfg_wdata sets the parallel threshold; write it only while
// the block is empty.
module ray_box_slab_intersect (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbsi_pkg::THR_W-1:0]    cfg_wdata,
  rbsi_in_if.sink                       in_ch,
  rbsi_out_if.source                    out_ch
);
  localparam int unsigned LAT = rbsi_pkg::PIPE_LAT;
  localparam int unsigned DW  = rbsi_pkg::DIST_W;

  // threshold register
  logic [rbsi_pkg::THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= '0;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  // pipeline advances while the skid slot is empty
  logic skid_v_r;
  logic en;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n)  vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // axis lanes
  rbsi_pkg::lane_res_t lres [rbsi_pkg::N_LANES];

  rbsi_lane u_lane_x (.clk(clk), .en(en), .thr_i(thr_r), .origin_i(in_ch.origin_x),
    .dir_i(in_ch.dir_x), .bmin_i(in_ch.box_min_x), .bmax_i(in_ch.box_max_x), .res_o(lres[0]));
  rbsi_lane u_lane_y (.clk(clk), .en(en), .thr_i(thr_r), .origin_i(in_ch.origin_y),
    .dir_i(in_ch.dir_y), .bmin_i(in_ch.box_min_y), .bmax_i(in_ch.box_max_y), .res_o(lres[1]));
  rbsi_lane u_lane_z (.clk(clk), .en(en), .thr_i(thr_r), .origin_i(in_ch.origin_z),
    .dir_i(in_ch.dir_z), .bmin_i(in_ch.box_min_z), .bmax_i(in_ch.box_max_z), .res_o(lres[2]));

  logic          p_hit;
  logic [DW-1:0] p_dist;
  rbsi_merge u_merge (.clk(clk), .en(en), .lane_i(lres), .hit_o(p_hit), .dist_o(p_dist));

  // output register plus skid slot
  logic          p_take;
  logic          out_v_r;
  logic          out_hit_r, skid_hit_r;
  logic [DW-1:0] out_dist_r, skid_dist_r;

  assign p_take = en && vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= p_take;
      end
    end else if (p_take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_hit_r  <= skid_hit_r;
        out_dist_r <= skid_dist_r;
      end else begin
        out_hit_r  <= p_hit;
        out_dist_r <= p_dist;
      end
    end else if (p_take) begin
      skid_hit_r  <= p_hit;
      skid_dist_r <= p_dist;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_distance = out_dist_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid slot full with no output beat");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid slot filled without a stalled output");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_hit_r) |-> (out_dist_r == '0))
    else $error("miss beat carries a distance");

endmodule

/* src/rbsi_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rbsi_pkg for numerator and divisor widths.
module rbsi_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rbsi_pkg::NUM_W-1:0]  num_i,
  input  logic [rbsi_pkg::DEN_W-1:0]  den_i,
  output logic [rbsi_pkg::NUM_W-1:0]  quo_o
);
  localparam int unsigned NB = rbsi_pkg::NUM_W;
  localparam int unsigned DW = rbsi_pkg::DEN_W;

  logic [DW-1:0] rem_r [NB];
  logic [NB-1:0] quo_r [NB];
  logic [NB-1:0] num_r [NB-1];
  logic [DW-1:0] den_r [NB-1];

  for (genvar k = 0; k < NB; k++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [NB-1:0] num_in;
    logic [NB-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    // shift in the next numerator bit and try one subtract
    assign trial = {rem_in, num_in[NB-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem_r[k] <= diff[DW-1:0];
          quo_r[k] <= {quo_in[NB-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[DW-1:0];
          quo_r[k] <= {quo_in[NB-2:0], 1'b0};
        end
      end
    end

    if (k < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k] <= {num_in[NB-2:0], 1'b0};
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[NB-1];

endmodule

/* src/rbsi_lane.sv */
// One axis lane: slab setup, two pipelined divides, saturate and order.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rbsi_pkg::THR_W-1:0]         thr_i,
  input  logic signed [rbsi_pkg::Q_W-1:0]    origin_i,
  input  logic signed [rbsi_pkg::Q_W-1:0]    dir_i,
  input  logic signed [rbsi_pkg::Q_W-1:0]    bmin_i,
  input  logic signed [rbsi_pkg::Q_W-1:0]    bmax_i,
  output rbsi_pkg::lane_res_t                res_o
);
  localparam int unsigned QW = rbsi_pkg::Q_W;
  localparam int unsigned DF = rbsi_pkg::DIFF_W;
  localparam int unsigned NW = rbsi_pkg::NUM_W;
  localparam int unsigned DL = rbsi_pkg::NUM_W;   // divider depth

  // setup: exact differences, magnitudes, signs, parallel test
  logic signed [DF-1:0] dlo, dhi;
  logic [DF-1:0]        alo, ahi;
  logic [QW-1:0]        dmag;

  assign dlo  = DF'(bmin_i) - DF'(origin_i);
  assign dhi  = DF'(bmax_i) - DF'(origin_i);
  assign alo  = dlo[DF-1] ? DF'(-dlo) : DF'(dlo);
  assign ahi  = dhi[DF-1] ? DF'(-dhi) : DF'(dhi);
  assign dmag = dir_i[QW-1] ? QW'(-dir_i) : QW'(dir_i);

  logic [NW-1:0] nlo_r, nhi_r;
  logic [QW-1:0] den_r;
  logic [3:0]    fl_r;   // {par, origin outside slab, neg_lo, neg_hi}

  always_ff @(posedge clk) begin
    if (en) begin
      nlo_r <= {alo, {rbsi_pkg::FRAC_W{1'b0}}};
      nhi_r <= {ahi, {rbsi_pkg::FRAC_W{1'b0}}};
      den_r <= dmag;
      fl_r  <= {dmag <= QW'(thr_i),
                (origin_i < bmin_i) || (origin_i > bmax_i),
                dlo[DF-1] ^ dir_i[QW-1],
                dhi[DF-1] ^ dir_i[QW-1]};
    end
  end

  // divides
  logic [NW-1:0] qlo, qhi;

  rbsi_div u_div_lo (.clk(clk), .en(en), .num_i(nlo_r), .den_i(den_r), .quo_o(qlo));
  rbsi_div u_div_hi (.clk(clk), .en(en), .num_i(nhi_r), .den_i(den_r), .quo_o(qhi));

  // flags ride alongside the divider stages
  logic [3:0] fd_r [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      fd_r[0] <= fl_r;
      for (int i = 1; i < DL; i++) fd_r[i] <= fd_r[i-1];
    end
  end

  // saturate signed quotient to the Q16.16 range
  function automatic logic signed [QW-1:0] sat_q(input logic neg, input logic [NW-1:0] q);
    logic big;
    big = |q[NW-1:QW-1];
    if (neg) sat_q = big ? rbsi_pkg::Q_MIN : QW'(-q[QW-1:0]);
    else     sat_q = big ? rbsi_pkg::Q_MAX : QW'(q[QW-1:0]);
  endfunction

  logic signed [QW-1:0] ta_r, tb_r;
  logic [1:0]           fs_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= sat_q(fd_r[DL-1][1], qlo);
      tb_r <= sat_q(fd_r[DL-1][0], qhi);
      fs_r <= fd_r[DL-1][3:2];
    end
  end

  // order entry and exit
  always_ff @(posedge clk) begin
    if (en) begin
      res_o.par      <= fs_r[1];
      res_o.par_miss <= fs_r[1] & fs_r[0];
      res_o.t0       <= (ta_r > tb_r) ? tb_r : ta_r;
      res_o.t1       <= (ta_r > tb_r) ? ta_r : tb_r;
    end
  end

endmodule

/* src/rbsi_merge.sv */
// Merge stage: narrows [0, max] by every non-parallel lane, forms the result.
// Depends on rbsi_pkg.
module rbsi_merge (
  input  logic                           clk,
  input  logic                           en,
  input  rbsi_pkg::lane_res_t            lane_i [rbsi_pkg::N_LANES],
  output logic                           hit_o,
  output logic [rbsi_pkg::DIST_W-1:0]    dist_o
);
  localparam int unsigned QW = rbsi_pkg::Q_W;

  logic signed [QW-1:0] near_c, far_c;
  logic                 miss_c;

  // interval over all lanes
  always_comb begin
    near_c = '0;
    far_c  = rbsi_pkg::Q_MAX;
    miss_c = 1'b0;
    for (int i = 0; i < rbsi_pkg::N_LANES; i++) begin
      miss_c = miss_c | lane_i[i].par_miss;
      if (!lane_i[i].par) begin
        if (lane_i[i].t0 > near_c) near_c = lane_i[i].t0;
        if (lane_i[i].t1 < far_c)  far_c  = lane_i[i].t1;
      end
    end
  end

  logic signed [QW-1:0] near_r, far_r;
  logic                 miss_r;
  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_c;
      far_r  <= far_c;
      miss_r <= miss_c;
    end
  end

  // final hit test; near is never negative
  always_ff @(posedge clk) begin
    if (en) begin
      hit_o  <= !miss_r && (near_r <= far_r);
      dist_o <= (!miss_r && (near_r <= far_r)) ? near_r[QW-2:0] : '0;
    end
  end

endmodule

/* tb/tb_ray_box_slab_intersect.sv */
// Testbench for ray_box_slab_intersect: random and directed ray/box beats,
// scoreboard predicts hit and entry distance per beat.
// Depends on rbsi_pkg, rbsi_in_if, rbsi_out_if and the block in src.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;

  typedef logic signed [rbsi_pkg::Q_W-1:0] coord_t;

  typedef struct {
    coord_t org [3];
    coord_t dir [3];
    coord_t bmin [3];
    coord_t bmax [3];
  } ray_box_t;

  typedef struct {
    logic                        hit;
    logic [rbsi_pkg::DIST_W-1:0] distance;
  } hit_res_t;

  // Scoreboard: predicts the slab test and checks results in order
  class slab_scoreboard;
    hit_res_t    pending_hits[$];
    logic [rbsi_pkg::THR_W-1:0] thresh;
    int          errors;

    function new();
      thresh = '0;
      errors = 0;
    endfunction

    function longint quot_sat(longint diff, longint d);
      longint q;
      q = (diff * 65536) / d;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_ray(ray_box_t r);
      longint nr, fr, o, d, lo, hi, mg, t0, t1, t;
      logic hit;
      hit_res_t e;
      nr = 0;
      fr = 64'sd2147483647;
      hit = 1'b1;
      for (int a = 0; a < 3 && hit; a++) begin
        o = r.org[a]; d = r.dir[a]; lo = r.bmin[a]; hi = r.bmax[a];
        mg = (d < 0) ? -d : d;
        if (mg <= longint'(thresh)) begin
          if (o < lo || o > hi) hit = 1'b0;
        end else begin
          t0 = quot_sat(lo - o, d);
          t1 = quot_sat(hi - o, d);
          if (t0 > t1) begin
            t = t0; t0 = t1; t1 = t;
          end
          if (t0 > nr) nr = t0;
          if (t1 < fr) fr = t1;
          if (nr > fr) hit = 1'b0;
        end
      end
      e.hit = hit;
      e.distance = hit ? nr[rbsi_pkg::DIST_W-1:0] : '0;
      pending_hits.push_back(e);
    endfunction

    function void check_hit(logic hit, logic [rbsi_pkg::DIST_W-1:0] hit_dist);
      hit_res_t e;
      if (pending_hits.size() == 0) begin
        $error("unexpected result beat hit=%0d hit_distance=%0h", hit, hit_dist);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, hit);
        errors++;
      end
      if (hit_dist !== e.distance) begin
        $error("hit_distance: expected %0h actual %0h", e.distance, hit_dist);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rbsi_pkg::THR_W-1:0] cfg_wdata;
  int unsigned cycle_cnt;
  bit no_idle;
  bit hold_off;

  rbsi_in_if  in_ch();
  rbsi_out_if out_ch();
  slab_scoreboard sb;

  ray_box_slab_intersect dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random coordinate: mix of extremes, small values and full range
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return rbsi_pkg::Q_MAX;
      1: return rbsi_pkg::Q_MIN;
      2: return '0;
      3, 4: return coord_t'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      5: return coord_t'($urandom_range(0, 255)) - 128;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Mostly well-formed boxes so hits are frequent
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    coord_t a, b;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = rand_coord();
      r.dir[i] = rand_coord();
      a = rand_coord();
      b = rand_coord();
      if ($urandom_range(0, 9) < 8 && a > b) begin
        r.bmin[i] = b; r.bmax[i] = a;
      end else begin
        r.bmin[i] = a; r.bmax[i] = b;
      end
    end
    return r;
  endfunction

  function automatic ray_box_t mk_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
    ray_box_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = o; r.dir[i] = d; r.bmin[i] = lo; r.bmax[i] = hi;
    end
    return r;
  endfunction

  // Offer one beat and wait until it is taken; valid stays high for the next
  task automatic send_ray(ray_box_t r);
    if (!no_idle && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 37) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.origin_x  <= r.org[0];  in_ch.origin_y  <= r.org[1];  in_ch.origin_z  <= r.org[2];
    in_ch.dir_x     <= r.dir[0];  in_ch.dir_y     <= r.dir[1];  in_ch.dir_z     <= r.dir[2];
    in_ch.box_min_x <= r.bmin[0]; in_ch.box_min_y <= r.bmin[1]; in_ch.box_min_z <= r.bmin[2];
    in_ch.box_max_x <= r.bmax[0]; in_ch.box_max_y <= r.bmax[1]; in_ch.box_max_z <= r.bmax[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_ray(r);
  endtask

  // Stop offering and wait for every result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (rbsi_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_thresh(logic [rbsi_pkg::THR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.thresh = v;
    @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off, otherwise quiet stretch
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_hit(out_ch.hit, out_ch.hit_distance);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 37);
    end
  end

  // Long hold-off counted here while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (cycle_cnt > 400);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 400000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [rbsi_pkg::THR_W-1:0] thr_set [4];
    ray_box_t r;
    sb = new();
    thr_set[0] = 16'h0000; thr_set[1] = 16'hFFFF;
    thr_set[2] = 16'h0100; thr_set[3] = 16'h8000;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
    {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} = '0;
    {in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero direction, extremes, inside, inverted box, saturation
    send_ray(mk_ray(0, 0, -32'sh10000, 32'sh10000));
    send_ray(mk_ray(32'sh20000, 0, -32'sh10000, 32'sh10000));
    send_ray(mk_ray(-32'sh50000, 32'sh10000, -32'sh10000, 32'sh10000));
    send_ray(mk_ray(32'sh50000, 32'sh10000, -32'sh10000, 32'sh10000));
    send_ray(mk_ray(0, 32'sh10000, 32'sh10000, -32'sh10000));
    send_ray(mk_ray(0, 0, 32'sh10000, -32'sh10000));
    send_ray(mk_ray(rbsi_pkg::Q_MIN, 1, rbsi_pkg::Q_MIN, rbsi_pkg::Q_MAX));
    send_ray(mk_ray(rbsi_pkg::Q_MIN, -1, rbsi_pkg::Q_MAX, rbsi_pkg::Q_MAX));
    send_ray(mk_ray(rbsi_pkg::Q_MAX, rbsi_pkg::Q_MIN, rbsi_pkg::Q_MIN, rbsi_pkg::Q_MAX));
    send_ray(mk_ray(rbsi_pkg::Q_MIN, rbsi_pkg::Q_MAX, rbsi_pkg::Q_MIN, rbsi_pkg::Q_MAX));
    send_ray(mk_ray(-32'sh30000, 32'sh8000, 0, 32'sh10000));
    send_ray(mk_ray(0, 16'hFFFF, -5, 5));
    send_ray(mk_ray(0, -32'sh10000, -32'sh10000, 32'sh10000));
    drain();

    // random phases at several thresholds
    for (int p = 0; p < 4; p++) begin
      write_thresh(thr_set[p]);
      r = mk_ray(0, 32'sh8000, -5, 5);
      send_ray(r);
      send_ray(mk_ray(0, -32'sh10000, -5, 5));
      send_ray(mk_ray(0, 32'shFFFF, -5, 5));
      for (int i = 0; i < 430; i++) begin
        no_idle = (p == 2 && i >= 100 && i < 300);
        if (p == 1 && $urandom_range(0, 3) == 0) begin
          r = rand_ray();
          r.dir[$urandom_range(0, 2)] = coord_t'($urandom_range(0, 32'h1_0000))
                                        - ($urandom_range(0, 1) ? 32'sh1_0000 : 0);
          send_ray(r);
        end else
          send_ray(rand_ray());
      end
      no_idle = 1'b0;
      drain();
    end

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/rbsi_pkg.sv
src/rbsi_in_if.sv
src/rbsi_out_if.sv
src/rbsi_div.sv
src/rbsi_lane.sv
src/rbsi_merge.sv
src/ray_box_slab_intersect.sv
tb/tb_ray_box_slab_intersect.sv
